// ----- hw/rtl/typed_operand_stack_defines.svh -----
// Assertion macros shared by the stack RTL.
`ifndef TYPED_OPERAND_STACK_DEFINES_SVH
`define TYPED_OPERAND_STACK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TOS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("typed_operand_stack: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TOS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("typed_operand_stack: next-cycle check failed");

`endif

// ----- hw/rtl/tos_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tos_pkg;

   localparam int STACK_DEPTH  = 256;
   localparam int PAYLOAD_BITS = 64;

   localparam int ADDR_BITS  = $clog2(STACK_DEPTH);
   localparam int COUNT_BITS = $clog2(STACK_DEPTH + 1);
   localparam int CMP_BITS   = (COUNT_BITS > 9) ? COUNT_BITS : 9;
   localparam int TAG_BITS   = 3;
   localparam int ENTRY_BITS = TAG_BITS + PAYLOAD_BITS;

   localparam logic [2:0] ACT_PUSH  = 3'd0;
   localparam logic [2:0] ACT_POP   = 3'd1;
   localparam logic [2:0] ACT_PEEK  = 3'd2;
   localparam logic [2:0] ACT_CLEAR = 3'd3;
   localparam logic [2:0] ACT_QUERY = 3'd4;
   localparam logic [2:0] ACT_READ  = 3'd5;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_OVERFLOW = 3'd2;
   localparam logic [2:0] ST_BOUNDS   = 3'd3;
   localparam logic [2:0] ST_MISMATCH = 3'd4;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_PEEK  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   localparam logic [8:0] LIMIT_RESET = 9'd256;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  depth_index;
      logic [2:0]  tag_in;
      logic [63:0] payload_in;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  tag_out;
      logic [63:0] payload_out;
      logic        type_match;
      logic [8:0]  entry_count;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tos_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tos_req_if;
   logic             valid;
   logic             ready;
   tos_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tos_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tos_rsp_if;
   logic             valid;
   logic             ready;
   tos_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tos_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/typed_operand_stack.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "typed_operand_stack_defines.svh"

// Typed operand stack: each entry is a 3-bit type tag plus a payload, kept in one
// single-port-per-side RAM with a registered read; the fill count lives in a
// register. A request transaction is accepted and its response transaction
// is presented on the following cycle, once the RAM read has returned; with the response
// side ready, one transaction per cycle is sustained. While a response waits, no new
// request is taken, and the RAM read data holds. Stack contents need no clearing after
// reset: only entries below the fill count are ever read. csr_wr_data sets the push
// limit (reset value 256); write it only while the block is idle.
module typed_operand_stack (
   input  wire logic       clock,
   input  wire logic       reset,
   tos_req_if.sink         req_chan,
   tos_rsp_if.source       rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [8:0] csr_wr_data
);

   localparam int CW = tos_pkg::CMP_BITS;

   logic [tos_pkg::COUNT_BITS-1:0] fill_ff, fill_in;
   logic [8:0]                     limit_ff;
   logic                           s1_valid_ff;
   logic [1:0]                     s1_kind_ff, s1_kind_in;
   logic [2:0]                     s1_status_ff, s1_status_in;
   logic [2:0]                     s1_tag_ff;

   logic                               accept;
   logic                               ram_we, ram_re;
   logic [tos_pkg::ADDR_BITS-1:0]      wr_addr, rd_addr;
   logic [tos_pkg::ENTRY_BITS-1:0]     rd_data;
   logic [2:0]                         rd_tag;
   logic [tos_pkg::PAYLOAD_BITS-1:0]   rd_payload;
   logic [CW-1:0]                      fill_w, depth_w, limit_w, pos_w;
   tos_pkg::req_type                   req;
   tos_pkg::rsp_type                   rsp;

   assign req      = req_chan.data;
   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !s1_valid_ff || rsp_chan.ready;

   assign fill_w  = CW'(fill_ff);
   assign depth_w = CW'(req.depth_index);
   assign limit_w = CW'(limit_ff);
   assign pos_w   = fill_w - CW'(1) - depth_w;
   assign wr_addr = tos_pkg::ADDR_BITS'(fill_ff);

   always_comb begin
      fill_in      = fill_ff;
      s1_kind_in   = tos_pkg::KIND_NONE;
      s1_status_in = tos_pkg::ST_OK;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      rd_addr      = tos_pkg::ADDR_BITS'(pos_w);
      unique case (req.action)
         tos_pkg::ACT_PUSH: begin
            if (fill_w >= limit_w || fill_w >= CW'(tos_pkg::STACK_DEPTH)) begin
               s1_status_in = tos_pkg::ST_OVERFLOW;
            end else begin
               ram_we  = accept;
               fill_in = fill_ff + 1'b1;
            end
         end
         tos_pkg::ACT_POP: begin
            if (fill_ff == '0) begin
               s1_status_in = tos_pkg::ST_EMPTY;
            end else begin
               fill_in = fill_ff - 1'b1;
            end
         end
         tos_pkg::ACT_PEEK: begin
            rd_addr = tos_pkg::ADDR_BITS'(fill_w - CW'(1));
            if (fill_ff == '0) begin
               s1_status_in = tos_pkg::ST_EMPTY;
            end else begin
               s1_kind_in = tos_pkg::KIND_PEEK;
               ram_re     = accept;
            end
         end
         tos_pkg::ACT_CLEAR: begin
            fill_in = '0;
         end
         tos_pkg::ACT_QUERY, tos_pkg::ACT_READ: begin
            if (depth_w >= fill_w) begin
               s1_status_in = tos_pkg::ST_BOUNDS;
            end else begin
               s1_kind_in = (req.action == tos_pkg::ACT_QUERY) ? tos_pkg::KIND_QUERY
                                                               : tos_pkg::KIND_READ;
               ram_re     = accept;
            end
         end
         default: begin
         end
      endcase
   end

   tos_ram #(
      .WIDTH(tos_pkg::ENTRY_BITS),
      .DEPTH(tos_pkg::STACK_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_addr),
      .wr_data({req.tag_in, req.payload_in[tos_pkg::PAYLOAD_BITS-1:0]}),
      .rd_en  (ram_re),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         limit_ff    <= tos_pkg::LIMIT_RESET;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (accept) begin
            fill_ff     <= fill_in;
            s1_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= s1_kind_in;
         s1_status_ff <= s1_status_in;
         s1_tag_ff    <= req.tag_in;
      end
   end

   assign rd_tag     = rd_data[tos_pkg::ENTRY_BITS-1 -: tos_pkg::TAG_BITS];
   assign rd_payload = rd_data[tos_pkg::PAYLOAD_BITS-1:0];

   always_comb begin
      rsp.status      = s1_status_ff;
      rsp.tag_out     = '0;
      rsp.payload_out = '0;
      rsp.type_match  = 1'b0;
      rsp.entry_count = 9'(fill_ff);
      unique case (s1_kind_ff)
         tos_pkg::KIND_PEEK: begin
            rsp.tag_out     = rd_tag;
            rsp.payload_out = 64'(rd_payload);
         end
         tos_pkg::KIND_QUERY: begin
            rsp.type_match = (rd_tag == s1_tag_ff);
         end
         tos_pkg::KIND_READ: begin
            rsp.tag_out = rd_tag;
            if (rd_tag == s1_tag_ff) begin
               rsp.payload_out = 64'(rd_payload);
            end else begin
               rsp.status = tos_pkg::ST_MISMATCH;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_chan.valid = s1_valid_ff;
   assign rsp_chan.data  = rsp;

   `TOS_ASSERT_SAME(a_write_only_on_push, clock, reset, ram_we, accept && req.action == tos_pkg::ACT_PUSH)
   `TOS_ASSERT_NEXT(a_clear_empties, clock, reset, accept && req.action == tos_pkg::ACT_CLEAR, fill_ff == '0)
   `TOS_ASSERT_NEXT(a_push_grows, clock, reset, ram_we, fill_ff == $past(fill_ff) + 1'b1)
   `TOS_ASSERT_SAME(a_count_matches, clock, reset, s1_valid_ff, rsp.entry_count == 9'(fill_ff) && fill_ff <= tos_pkg::COUNT_BITS'(tos_pkg::STACK_DEPTH))

endmodule

`default_nettype wire

// ----- tb/sv/typed_operand_stack_tb.sv -----
`timescale 1ns / 1ps

module typed_operand_stack_tb;
   import tos_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SCRIPT_ROWS = 25;
   localparam int PHASE_COUNT = 5;
   localparam int HOLD_AFTER  = 300;
   localparam int HOLD_CYCLES = 250;

   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   localparam logic [2:0] TAG_BOOL     = 3'd0;
   localparam logic [2:0] TAG_NATIVE   = 3'd1;
   localparam logic [2:0] TAG_F32      = 3'd2;
   localparam logic [2:0] TAG_I32      = 3'd3;
   localparam logic [2:0] TAG_OBJECT   = 3'd4;
   localparam logic [2:0] TAG_VOID     = 3'd5;
   localparam logic [2:0] TAG_SPARE_LO = 3'd6;
   localparam logic [2:0] TAG_SPARE_HI = 3'd7;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type want;
   } script_row;

   typedef struct {
      int unsigned limit;
      int          items;
      int          push_pct;
      bit          clears;
   } phase_plan;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [8:0] csr_wr_data;

   tos_req_if req_bus ();
   tos_rsp_if rsp_bus ();

   typed_operand_stack i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [2:0]  shadow_tags     [STACK_DEPTH];
   logic [63:0] shadow_payloads [STACK_DEPTH];
   int unsigned shadow_fill  = 0;
   int unsigned shadow_limit = 256;
   int unsigned deepest_fill = 0;

   rsp_type pending_outcomes [$];

   int mismatches       = 0;
   int results_checked  = 0;
   int settings_applied = 0;
   int burst_left       = 0;
   int cycle_count      = 0;
   int rx_cycle         = 0;
   int hold_left        = 0;
   bit hold_done        = 1'b0;
   int status_tally [8] = '{default: 0};

   script_row directed_script [SCRIPT_ROWS] = '{
      '{'{ACT_POP, 8'd0, TAG_BOOL, 64'd0}, 1'b1, '{ST_EMPTY, TAG_BOOL, 64'd0, 1'b0, 9'd0}},
      '{'{ACT_PEEK, 8'd0, TAG_BOOL, 64'd0}, 1'b1, '{ST_EMPTY, TAG_BOOL, 64'd0, 1'b0, 9'd0}},
      '{'{ACT_QUERY, 8'd0, TAG_BOOL, 64'd0}, 1'b1, '{ST_BOUNDS, TAG_BOOL, 64'd0, 1'b0, 9'd0}},
      '{'{ACT_READ, 8'd255, TAG_SPARE_HI, ALL_ONES}, 1'b1,
        '{ST_BOUNDS, TAG_BOOL, 64'd0, 1'b0, 9'd0}},
      '{'{ACT_PUSH, 8'd0, TAG_BOOL, ALL_ONES}, 1'b1, '{ST_OK, TAG_BOOL, 64'd0, 1'b0, 9'd1}},
      '{'{ACT_PUSH, 8'd255, TAG_SPARE_HI, 64'd0}, 1'b1,
        '{ST_OK, TAG_BOOL, 64'd0, 1'b0, 9'd2}},
      '{'{ACT_PEEK, 8'd0, TAG_BOOL, 64'd0}, 1'b1, '{ST_OK, TAG_SPARE_HI, 64'd0, 1'b0, 9'd2}},
      '{'{ACT_QUERY, 8'd1, TAG_BOOL, 64'd0}, 1'b1, '{ST_OK, TAG_BOOL, 64'd0, 1'b1, 9'd2}},
      '{'{ACT_QUERY, 8'd0, TAG_BOOL, 64'd0}, 1'b1, '{ST_OK, TAG_BOOL, 64'd0, 1'b0, 9'd2}},
      '{'{ACT_READ, 8'd1, TAG_BOOL, 64'd0}, 1'b1, '{ST_OK, TAG_BOOL, ALL_ONES, 1'b0, 9'd2}},
      '{'{ACT_READ, 8'd1, TAG_I32, 64'd0}, 1'b1, '{ST_MISMATCH, TAG_BOOL, 64'd0, 1'b0, 9'd2}},
      '{'{ACT_READ, 8'd0, TAG_SPARE_LO, 64'd0}, 1'b1,
        '{ST_MISMATCH, TAG_SPARE_HI, 64'd0, 1'b0, 9'd2}},
      '{'{ACT_QUERY, 8'd2, TAG_BOOL, 64'd0}, 1'b1, '{ST_BOUNDS, TAG_BOOL, 64'd0, 1'b0, 9'd2}},
      '{'{ACT_SPARE_LO, 8'd255, TAG_SPARE_HI, ALL_ONES}, 1'b1,
        '{ST_OK, TAG_BOOL, 64'd0, 1'b0, 9'd2}},
      '{'{ACT_SPARE_HI, 8'd0, TAG_BOOL, 64'd0}, 1'b1, '{ST_OK, TAG_BOOL, 64'd0, 1'b0, 9'd2}},
      '{'{ACT_PUSH, 8'd0, TAG_VOID, 64'h8000_0000_0000_0001}, 1'b0, '0},
      '{'{ACT_PUSH, 8'd0, TAG_F32, 64'h0123_4567_89AB_CDEF}, 1'b0, '0},
      '{'{ACT_PUSH, 8'd0, TAG_NATIVE, 64'h5555_5555_5555_5555}, 1'b0, '0},
      '{'{ACT_PUSH, 8'd0, TAG_OBJECT, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, '0},
      '{'{ACT_PUSH, 8'd0, TAG_I32, 64'h0000_0000_7FFF_FFFF}, 1'b0, '0},
      '{'{ACT_READ, 8'd5, TAG_SPARE_HI, 64'd0}, 1'b0, '0},
      '{'{ACT_POP, 8'd0, TAG_BOOL, 64'd0}, 1'b1, '{ST_OK, TAG_BOOL, 64'd0, 1'b0, 9'd6}},
      '{'{ACT_CLEAR, 8'd0, TAG_BOOL, 64'd0}, 1'b1, '{ST_OK, TAG_BOOL, 64'd0, 1'b0, 9'd0}},
      '{'{ACT_PUSH, 8'd0, TAG_F32, 64'd0}, 1'b1, '{ST_OK, TAG_BOOL, 64'd0, 1'b0, 9'd1}},
      '{'{ACT_PEEK, 8'd0, TAG_BOOL, 64'd0}, 1'b1, '{ST_OK, TAG_F32, 64'd0, 1'b0, 9'd1}}
   };

   phase_plan plan [PHASE_COUNT] = '{
      '{256, 500, 70, 1'b0},
      '{5,   150, 50, 1'b0},
      '{1,   150, 20, 1'b1},
      '{256, 400, 55, 1'b1},
      '{128, 350, 50, 1'b1}
   };

   function automatic rsp_type stack_outcome(input req_type r);
      rsp_type     o;
      int unsigned usable;
      logic [7:0]  slot;
      o = '0;
      usable = (shadow_limit < STACK_DEPTH) ? shadow_limit : STACK_DEPTH;
      case (r.action)
         ACT_PUSH: begin
            if (shadow_fill >= usable) begin
               o.status = ST_OVERFLOW;
            end else begin
               shadow_tags[8'(shadow_fill)]     = r.tag_in;
               shadow_payloads[8'(shadow_fill)] = r.payload_in;
               shadow_fill++;
            end
         end
         ACT_POP: begin
            if (shadow_fill == 0) o.status = ST_EMPTY;
            else shadow_fill--;
         end
         ACT_PEEK: begin
            if (shadow_fill == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.tag_out     = shadow_tags[8'(shadow_fill - 1)];
               o.payload_out = shadow_payloads[8'(shadow_fill - 1)];
            end
         end
         ACT_CLEAR: begin
            shadow_fill = 0;
         end
         ACT_QUERY, ACT_READ: begin
            if (r.depth_index >= shadow_fill) begin
               o.status = ST_BOUNDS;
            end else begin
               slot = 8'(shadow_fill - 1 - r.depth_index);
               if (r.action == ACT_QUERY) begin
                  o.type_match = (shadow_tags[slot] == r.tag_in);
               end else begin
                  o.tag_out = shadow_tags[slot];
                  if (shadow_tags[slot] != r.tag_in) o.status = ST_MISMATCH;
                  else o.payload_out = shadow_payloads[slot];
               end
            end
         end
         default: begin
         end
      endcase
      if (shadow_fill > deepest_fill) deepest_fill = shadow_fill;
      o.entry_count = shadow_fill[8:0];
      return o;
   endfunction

   function automatic req_type random_item(input int push_pct, input bit allow_clear);
      req_type     r;
      int unsigned pick;
      if (shadow_fill > 0 && $urandom_range(0, 9) < 8) begin
         r.depth_index = 8'($urandom_range(0, shadow_fill - 1));
      end else begin
         r.depth_index = 8'($urandom_range(0, 255));
      end
      r.tag_in = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
      case ($urandom_range(0, 7))
         0: r.payload_in = ALL_ONES;
         1: r.payload_in = 64'd0;
         default: r.payload_in = {$urandom, $urandom};
      endcase
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
         r.action = ACT_PUSH;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 25) r.action = ACT_POP;
         else if (pick < 35) r.action = ACT_PEEK;
         else if (pick < 37) r.action = allow_clear ? ACT_CLEAR : ACT_POP;
         else if (pick < 65) r.action = ACT_QUERY;
         else if (pick < 98) r.action = ACT_READ;
         else r.action = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
         // aim most tag checks at the tag actually stored there
         if ((r.action == ACT_QUERY || r.action == ACT_READ) && r.depth_index < shadow_fill
               && $urandom_range(0, 9) < 7) begin
            r.tag_in = shadow_tags[8'(shadow_fill - 1 - r.depth_index)];
         end
      end
      return r;
   endfunction

   function automatic void flag_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_item(input req_type r, input bit fixed, input rsp_type want);
      rsp_type got;
      int      gap;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.data  <= r;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      got = stack_outcome(r);
      pending_outcomes.push_back(fixed ? want : got);
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end else begin
         burst_left--;
      end
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_requests();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_depth_limit(input logic [8:0] value);
      drain_requests();
      repeat (3) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      shadow_limit = 32'(value);
      settings_applied++;
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_checked++;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected response transaction, expected none, actual %p",
                     $time, rsp_bus.data);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            flag_field("status", 64'(want.status), 64'(rsp_bus.data.status));
            flag_field("tag_out", 64'(want.tag_out), 64'(rsp_bus.data.tag_out));
            flag_field("payload_out", want.payload_out, rsp_bus.data.payload_out);
            flag_field("type_match", 64'(want.type_match), 64'(rsp_bus.data.type_match));
            flag_field("entry_count", 64'(want.entry_count), 64'(rsp_bus.data.entry_count));
            status_tally[want.status]++;
         end
      end
   end

   // hold off once for a long stretch, otherwise rotate through stall patterns
   always @(negedge clock) begin
      rx_cycle++;
      if (!hold_done && results_checked >= HOLD_AFTER) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case ((rx_cycle / 97) % 3)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_bus.ready <= ($urandom_range(0, 2) == 0);
         endcase
      end
   end

   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;
      plan[PHASE_COUNT - 1].limit = $urandom_range(2, 255);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_script[i]) begin
         send_item(directed_script[i].item, directed_script[i].fixed, directed_script[i].want);
      end

      foreach (plan[p]) begin
         write_depth_limit(plan[p].limit[8:0]);
         for (int n = 0; n < plan[p].items; n++) begin
            send_item(random_item(plan[p].push_pct, plan[p].clears), 1'b0, '0);
         end
      end

      drain_requests();
      repeat (10) @(posedge clock);

      $display("Checked %0d response transactions over %0d depth-limit settings, deepest fill %0d.",
               results_checked, settings_applied, deepest_fill);
      $display("Status mix: ok %0d, empty %0d, overflow %0d, out of bounds %0d, type mismatch %0d.",
               status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_OVERFLOW],
               status_tally[ST_BOUNDS], status_tally[ST_MISMATCH]);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
